[hdl/udf_pkg.sv]
// shared constants, types and helpers of the unsigned decimal field formatter
`default_nettype none
package udf_pkg;

   // field limit and digit count of a 32-bit value
   localparam int MAX_FIELD  = 64;
   localparam int NUM_DIGITS = 10;
   localparam int LEN_W      = 7;
   localparam int DCNT_W     = 4;

   // reciprocal of ten: q = (v * RECIP_TEN) >> RECIP_SHIFT is exact for 32-bit v
   localparam logic [32:0] RECIP_TEN   = 33'h0CCCCCCCD;
   localparam int          RECIP_SHIFT = 35;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // register indexes
   localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
   localparam logic [1:0] REG_MIN_DIGITS   = 2'd1;
   localparam logic [1:0] REG_LEFT_JUSTIFY = 2'd2;
   localparam logic [1:0] REG_ZERO_PAD     = 2'd3;

   typedef logic [4*NUM_DIGITS-1:0] digit_vec_type;

   // what one cell hands to the next
   typedef struct packed {
      logic          valid;
      logic [31:0]   quot;
      digit_vec_type digs;
   } cell_type;

   // segment lengths of one field, ready for the emitter
   typedef struct packed {
      logic              valid;
      logic [LEN_W-1:0]  lead;
      logic [LEN_W-1:0]  zeros;
      logic [DCNT_W-1:0] ndig;
      logic [LEN_W-1:0]  trail;
      logic [LEN_W-1:0]  total;
      logic              pad_zero;
      digit_vec_type     digs;
   } plan_type;

   // pick one bcd digit, least significant at index 0
   function automatic logic [3:0] digit_at(digit_vec_type vec, logic [DCNT_W-1:0] idx);
      logic [3:0] result;
      result = 4'd0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (idx == DCNT_W'(k)) begin
            result = vec[4*k +: 4];
         end
      end
      return result;
   endfunction

endpackage
`default_nettype wire

[hdl/udf_cell.sv]
// one divide-by-ten cell of the digit extraction chain
`default_nettype none
module udf_cell
   import udf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire cell_type cell_in,
   output cell_type      cell_out
);

   logic [64:0]   prod;
   logic [31:0]   quot;
   logic [31:0]   times_ten;
   logic [31:0]   rem;
   logic          valid_ff;
   logic [31:0]   quot_ff;
   digit_vec_type digs_ff;

   // quotient by reciprocal multiply, remainder by shift-add
   always_comb begin
      prod      = 65'(cell_in.quot) * 65'(RECIP_TEN);
      quot      = 32'(prod >> RECIP_SHIFT);
      times_ten = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
      rem       = cell_in.quot - times_ten;
   end

   // new digit enters at the top, earlier digits move down one slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot;
         digs_ff <= {rem[3:0], cell_in.digs[4*NUM_DIGITS-1:4]};
      end
   end

   assign cell_out = '{valid: valid_ff, quot: quot_ff, digs: digs_ff};

endmodule
`default_nettype wire

[hdl/udf_plan.sv]
// field layout stage: digit count, precision zeros and padding lengths
`default_nettype none
module udf_plan
   import udf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire cell_type         cell_in,
   input  wire logic [LEN_W-1:0] field_width,
   input  wire logic [7:0]       min_digits,
   input  wire logic             left_justify,
   input  wire logic             zero_pad,
   output plan_type              plan_out
);

   logic [DCNT_W-1:0] ndig;
   logic [LEN_W-1:0]  ndig_ext;
   logic [LEN_W-1:0]  prec;
   logic [LEN_W-1:0]  width;
   logic [LEN_W-1:0]  body;
   logic [LEN_W-1:0]  fill;
   logic              empty;
   plan_type          plan_in;
   plan_type          plan_ff;

   // digit count: highest nonzero digit, at least one
   always_comb begin
      ndig = DCNT_W'(1);
      for (int k = 1; k < NUM_DIGITS; k++) begin
         if (cell_in.digs[4*k +: 4] != 4'd0) begin
            ndig = DCNT_W'(k + 1);
         end
      end
   end

   // saturated settings and segment lengths
   always_comb begin
      ndig_ext = LEN_W'(ndig);
      if (min_digits[7]) begin
         prec = '0;
      end else if (min_digits > 8'(MAX_FIELD)) begin
         prec = LEN_W'(MAX_FIELD);
      end else begin
         prec = min_digits[LEN_W-1:0];
      end
      width = (field_width > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : field_width;
      empty = (min_digits == 8'd0) && (cell_in.digs == '0);
      if (empty) begin
         body = '0;
      end else begin
         body = (prec > ndig_ext) ? prec : ndig_ext;
      end
      fill = (width > body) ? width - body : '0;

      plan_in.valid    = cell_in.valid;
      plan_in.lead     = left_justify ? '0 : fill;
      plan_in.trail    = left_justify ? fill : '0;
      plan_in.zeros    = empty ? '0 : body - ndig_ext;
      plan_in.ndig     = empty ? '0 : ndig;
      plan_in.total    = fill + body;
      plan_in.pad_zero = zero_pad;
      plan_in.digs     = cell_in.digs;
   end

   // layout register, only the valid flag is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_ff.valid <= 1'b0;
      end else if (advance) begin
         plan_ff <= plan_in;
      end
   end

   assign plan_out = plan_ff;

endmodule
`default_nettype wire

[hdl/udf_emit.sv]
// character emitter: walks the field segments one character per cycle while rsp is not stalled
`default_nettype none
module udf_emit
   import udf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire plan_type plan_in,
   output logic          take,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [7:0]    rsp_char_code,
   output logic          rsp_last_char
);

   logic [LEN_W-1:0]  rem_ff,   rem_in;
   logic [LEN_W-1:0]  lead_ff,  lead_in;
   logic [LEN_W-1:0]  zeros_ff, zeros_in;
   logic [DCNT_W-1:0] ndig_ff,  ndig_in;
   logic [LEN_W-1:0]  trail_ff, trail_in;
   logic              pad_zero_ff;
   digit_vec_type     digs_ff;
   logic              ovalid_ff, ovalid_in;
   logic [7:0]        char_ff,   char_in;
   logic              last_ff,   last_in;
   logic              out_free;
   logic              step;
   logic [7:0]        cur_char;

   // output register frees when empty or its transaction completes
   assign out_free = !ovalid_ff || !rsp_stall;
   assign step     = out_free && (rem_ff != '0);
   assign take     = plan_in.valid && ((rem_ff == '0) || (step && (rem_ff == LEN_W'(1))));

   // character of the current position and segment countdown
   always_comb begin
      lead_in  = lead_ff;
      zeros_in = zeros_ff;
      ndig_in  = ndig_ff;
      trail_in = trail_ff;
      priority if (lead_ff != '0) begin
         cur_char = pad_zero_ff ? CHAR_ZERO : CHAR_SPACE;
         lead_in  = lead_ff - LEN_W'(1);
      end else if (zeros_ff != '0) begin
         cur_char = CHAR_ZERO;
         zeros_in = zeros_ff - LEN_W'(1);
      end else if (ndig_ff != '0) begin
         cur_char = CHAR_ZERO + 8'(digit_at(digs_ff, ndig_ff - DCNT_W'(1)));
         ndig_in  = ndig_ff - DCNT_W'(1);
      end else begin
         cur_char = CHAR_SPACE;
         trail_in = trail_ff - LEN_W'(1);
      end
      rem_in = rem_ff - LEN_W'(1);
   end

   // segment counters: load a new field or count down
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (take) begin
         rem_ff <= plan_in.total;
      end else if (step) begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         lead_ff     <= plan_in.lead;
         zeros_ff    <= plan_in.zeros;
         ndig_ff     <= plan_in.ndig;
         trail_ff    <= plan_in.trail;
         pad_zero_ff <= plan_in.pad_zero;
         digs_ff     <= plan_in.digs;
      end else if (step) begin
         lead_ff  <= lead_in;
         zeros_ff <= zeros_in;
         ndig_ff  <= ndig_in;
         trail_ff <= trail_in;
      end
   end

   // output register
   always_comb begin
      ovalid_in = step;
      char_in   = cur_char;
      last_in   = (rem_ff == LEN_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (out_free) begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = ovalid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

endmodule
`default_nettype wire

[hdl/unsigned_decimal_field_formatter_core.sv]
// top level of the unsigned decimal field formatter: registers, cell chain, layout stage, emitter
//
//   channel   direction  signals                                   transaction
//   req       in         req_valid, req_stall, req_value            one 32-bit value
//   rsp       out        rsp_valid, rsp_stall, rsp_char_code,       one ascii character
//                        rsp_last_char
//   csr       in/out     psel, penable, pwrite, paddr, pwdata,      one register access
//                        prdata, pready
//
// a value passes ten divide-by-ten cells, a layout stage, the emitter load and the output
// register before its first character shows, when the emitter is idle.
// the emitter sends one character per cycle while rsp is not stalled, and it loads the
// next layout while the last character of a field is sent.
// synchronous reset clears valid flags and restores register defaults.
// a stall on rsp holds the output register; the chain moves only when the layout
// stage is empty or taken, so req_stall is high while a layout waits for the emitter.
`default_nettype none
module unsigned_decimal_field_formatter_core
   import udf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_char_code,
   output logic             rsp_last_char,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [LEN_W-1:0] field_width_ff;
   logic [7:0]       min_digits_ff;
   logic             left_justify_ff;
   logic             zero_pad_ff;
   logic             csr_write;
   logic             advance;
   logic             take;
   cell_type         chain [0:NUM_DIGITS];
   plan_type         plan;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff  <= '0;
         min_digits_ff   <= 8'hFF;
         left_justify_ff <= 1'b0;
         zero_pad_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_FIELD_WIDTH:  field_width_ff  <= pwdata[LEN_W-1:0];
            REG_MIN_DIGITS:   min_digits_ff   <= pwdata[7:0];
            REG_LEFT_JUSTIFY: left_justify_ff <= pwdata[0];
            REG_ZERO_PAD:     zero_pad_ff     <= pwdata[0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[3:2])
         REG_FIELD_WIDTH:  prdata = 32'(field_width_ff);
         REG_MIN_DIGITS:   prdata = 32'(min_digits_ff);
         REG_LEFT_JUSTIFY: prdata = 32'(left_justify_ff);
         REG_ZERO_PAD:     prdata = 32'(zero_pad_ff);
      endcase
   end

   // the whole chain moves when the layout stage is free or handed to the emitter
   assign advance   = !plan.valid || take;
   assign req_stall = !advance;

   assign chain[0] = '{valid: req_valid, quot: req_value, digs: '0};

   // digit extraction chain, one decimal digit per cell
   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
      udf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   // field layout
   udf_plan u_plan (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cell_in      (chain[NUM_DIGITS]),
      .field_width  (field_width_ff),
      .min_digits   (min_digits_ff),
      .left_justify (left_justify_ff),
      .zero_pad     (zero_pad_ff),
      .plan_out     (plan)
   );

   // character output
   udf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .plan_in       (plan),
      .take          (take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule
`default_nettype wire

[tb/unsigned_decimal_field_formatter_core_tb.sv]
// self-checking testbench for the unsigned decimal field formatter core
module unsigned_decimal_field_formatter_core_tb;
   import udf_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_VALUES   = 50;
   localparam int STALL_SPAN     = 60;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // one expected character of a formatted field
   typedef struct {
      logic [31:0] value;
      logic [7:0]  code;
      logic        last;
   } field_char_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [31:0] req_value     = '0;
   logic        rsp_stall     = 1'b0;
   logic        psel          = 1'b0;
   logic        penable       = 1'b0;
   logic        pwrite        = 1'b0;
   logic [3:0]  paddr         = '0;
   logic [31:0] pwdata        = '0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [7:0]  rsp_char_code;
   wire         rsp_last_char;
   wire  [31:0] prdata;
   wire         pready;

   // shadow copy of the format registers
   logic [6:0]        fmt_width     = 7'd0;
   logic signed [7:0] fmt_precision = -8'sd1;
   logic              fmt_left      = 1'b0;
   logic              fmt_zero      = 1'b0;

   field_char_type field_q[$];
   int             mismatches  = 0;
   int             burst_left  = 0;
   int             idle_cycles = 0;
   int             stall_tick  = 0;
   stall_mode_type stall_mode  = STALL_NONE;

   unsigned_decimal_field_formatter_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // receiver stall pattern, switching style every span
   always @(posedge clock) begin
      if (stall_tick % STALL_SPAN == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_tick % 7) < 3);
      endcase
      stall_tick++;
   end

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endtask

   // compare each character transaction with the oldest expectation
   always @(posedge clock) begin
      field_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (field_q.size() == 0) begin
            note_mismatch($sformatf("unexpected char_code %h last_char %b",
                                    rsp_char_code, rsp_last_char));
         end else begin
            want = field_q.pop_front();
            if (rsp_char_code !== want.code || rsp_last_char !== want.last) begin
               note_mismatch($sformatf(
                  "value %0d: char_code expected %h got %h, last_char expected %b got %b",
                  want.value, want.code, rsp_char_code, want.last, rsp_last_char));
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // expected characters of one value's decimal field under the current format
   task automatic expect_field(input logic [31:0] value);
      logic [3:0]     digit [10];
      logic [7:0]     text [$];
      logic [31:0]    rest;
      int             ndig, prec, width, body, zeros, fill;
      bit             empty;
      field_char_type entry;
      rest  = value;
      ndig  = 0;
      prec  = int'(fmt_precision);
      width = int'(fmt_width);
      if (prec > MAX_FIELD) prec = MAX_FIELD;
      if (width > MAX_FIELD) width = MAX_FIELD;
      // digits, least significant first; zero still has one digit
      do begin
         digit[ndig] = 4'(rest % 10);
         rest = rest / 10;
         ndig++;
      end while (rest != 0);
      empty = (prec == 0) && (value == 0);
      body  = empty ? 0 : ((prec > ndig) ? prec : ndig);
      zeros = empty ? 0 : body - ndig;
      fill  = (width > body) ? width - body : 0;
      if (!fmt_left) begin
         repeat (fill) text.push_back(fmt_zero ? CHAR_ZERO : CHAR_SPACE);
      end
      if (!empty) begin
         repeat (zeros) text.push_back(CHAR_ZERO);
         for (int i = ndig - 1; i >= 0; i--) text.push_back(CHAR_ZERO + 8'(digit[i]));
      end
      if (fmt_left) begin
         repeat (fill) text.push_back(CHAR_SPACE);
      end
      foreach (text[i]) begin
         entry.value = value;
         entry.code  = text[i];
         entry.last  = (i == text.size() - 1);
         field_q.push_back(entry);
      end
   endtask

   // send one value, in bursts with random gaps between them
   task automatic send_value(input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      expect_field(value);
   endtask

   // one register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_FIELD_WIDTH:  fmt_width     = data[6:0];
         REG_MIN_DIGITS:   fmt_precision = data[7:0];
         REG_LEFT_JUSTIFY: fmt_left      = data[0];
         REG_ZERO_PAD:     fmt_zero      = data[0];
         default: ;
      endcase
   endtask

   // write all four format registers, junk in the unused upper bits
   task automatic set_format(input logic [6:0] width, input logic signed [7:0] prec,
                             input logic left, input logic zero);
      logic [31:0] junk;
      junk = $urandom();
      csr_write(REG_FIELD_WIDTH, {junk[31:7], width});
      junk = $urandom();
      csr_write(REG_MIN_DIGITS, {junk[31:8], prec});
      junk = $urandom();
      csr_write(REG_LEFT_JUSTIFY, {junk[31:1], left});
      junk = $urandom();
      csr_write(REG_ZERO_PAD, {junk[31:1], zero});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // stop sending, let every expected character arrive, then let the pipe drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (field_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // reset format: plain digits, extremes of the value
   task automatic test_reset_defaults();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd1000000000);
      send_value(32'd999999999);
      send_value(32'hFFFFFFFF);
      wait_idle();
   endtask

   // saturation, empty field, negative precision and padding priorities
   task automatic test_directed_formats();
      set_format(64, -1, 1'b0, 1'b0);
      send_value(32'hFFFFFFFF);
      send_value(32'd0);
      wait_idle();
      // width and precision both past the limit, zero pad with precision
      set_format(127, 127, 1'b0, 1'b1);
      send_value(32'd7);
      wait_idle();
      // zero precision on zero gives an empty field
      set_format(0, 0, 1'b0, 1'b0);
      send_value(32'd0);
      send_value(32'd5);
      send_value(32'd0);
      wait_idle();
      set_format(3, 0, 1'b0, 1'b0);
      send_value(32'd0);
      wait_idle();
      set_format(3, 0, 1'b1, 1'b0);
      send_value(32'd0);
      wait_idle();
      // most negative precision means not given
      set_format(5, -128, 1'b0, 1'b0);
      send_value(32'd123);
      wait_idle();
      // left justify beats zero pad
      set_format(10, -1, 1'b1, 1'b1);
      send_value(32'd77);
      wait_idle();
      set_format(10, 5, 1'b0, 1'b1);
      send_value(32'd12);
      wait_idle();
      set_format(0, 65, 1'b0, 1'b0);
      send_value(32'hFFFFFFFF);
      wait_idle();
      set_format(64, 64, 1'b1, 1'b0);
      send_value(32'd3);
      wait_idle();
   endtask

   // random formats per phase, random values spread over digit counts
   task automatic test_random_fields();
      logic [31:0] value;
      int          width, prec, pick, nd;
      int unsigned lo, hi;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               width = 127;
               prec  = 127;
            end
            1: begin
               width = 0;
               prec  = 0;
            end
            2: begin
               width = 64;
               prec  = -128;
            end
            default: begin
               pick = $urandom_range(0, 9);
               case (pick)
                  0:       width = 0;
                  1:       width = 64;
                  2:       width = 127;
                  3:       width = $urandom_range(65, 126);
                  default: width = $urandom_range(1, 20);
               endcase
               pick = $urandom_range(0, 7);
               case (pick)
                  0:       prec = -1;
                  1:       prec = 0;
                  2:       prec = 64;
                  3:       prec = 127;
                  4:       prec = -int'($urandom_range(2, 128));
                  5:       prec = $urandom_range(65, 126);
                  default: prec = $urandom_range(1, 14);
               endcase
            end
         endcase
         set_format(7'(width), 8'(prec), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         repeat (PHASE_VALUES) begin
            pick = $urandom_range(0, 9);
            nd   = $urandom_range(1, 9);
            lo   = 1;
            repeat (nd - 1) lo = lo * 10;
            hi   = lo * 10 - 1;
            case (pick)
               0:       value = 32'd0;
               1:       value = 32'hFFFFFFFF;
               2:       value = hi + $urandom_range(0, 1);
               3, 4, 5: value = $urandom_range(hi, lo);
               default: value = $urandom();
            endcase
            send_value(value);
         end
         wait_idle();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_formats();
      test_random_fields();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
